// ===== design/rqscp_pkg.sv =====
// Shared types, constants and helpers for the request queue with size-class pool
package rqscp_pkg;

    // Queue and pool dimensions
    localparam int QUEUE_DEPTH    = 8;
    localparam int SMALL_BUFFERS  = 8;
    localparam int MEDIUM_BUFFERS = 4;
    localparam int LARGE_BUFFERS  = 2;
    localparam int POOL_MAX       = 8;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = $clog2(POOL_MAX);
    localparam int CLS_W  = 2;
    localparam int LEN_W  = 16;
    localparam int ADDR_W = 16;
    localparam int KIND_W = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_SMALL_BYTES  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEDIUM_BYTES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LARGE_BYTES  = 2'd2;

    localparam logic [LEN_W-1:0] SMALL_BYTES_RST  = 16'd64;
    localparam logic [LEN_W-1:0] MEDIUM_BYTES_RST = 16'd256;
    localparam logic [LEN_W-1:0] LARGE_BYTES_RST  = 16'd4096;

    // Stream widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_UNUSED  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOFIT  = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [CLS_W-1:0] {
        CLS_SMALL  = 2'd0,
        CLS_MEDIUM = 2'd1,
        CLS_LARGE  = 2'd2,
        CLS_NONE   = 2'd3
    } buf_class_t;

    // Output register occupancy
    typedef enum logic {
        OUT_EMPTY = 1'b0,
        OUT_FULL  = 1'b1
    } ctrl_state_t;

    // One request as it arrives on the input stream
    typedef struct packed {
        action_t            action;
        logic [KIND_W-1:0]  msg_kind;
        logic [ADDR_W-1:0]  remote_addr;
        logic [ADDR_W-1:0]  source_addr;
        logic [ADDR_W-1:0]  target_addr;
        logic               target_is_functional;
        logic [LEN_W-1:0]   payload_len;
    } request_t;

    // One queued descriptor with its buffer
    typedef struct packed {
        logic [KIND_W-1:0]  msg_kind;
        logic [ADDR_W-1:0]  remote_addr;
        logic [ADDR_W-1:0]  source_addr;
        logic [ADDR_W-1:0]  target_addr;
        logic               target_is_functional;
        logic [LEN_W-1:0]   payload_len;
        buf_class_t         buf_class;
        logic [IDX_W-1:0]   buf_index;
    } entry_t;

    // One result as it leaves on the output stream
    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   entry_count;
        logic               head_valid;
        entry_t             head;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } pick_t;

    // Lowest clear bit of a used-flag vector
    function automatic pick_t lowest_free(input logic [POOL_MAX-1:0] used);
        pick_t res;
        res.found = 1'b0;
        res.index = '0;
        for (int i = POOL_MAX - 1; i >= 0; i--) begin
            if (!used[i]) begin
                res.found = 1'b1;
                res.index = IDX_W'(i);
            end
        end
        return res;
    endfunction

    // Circular pointer advance
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== design/rqscp_ctrl.sv =====
// Output-register controller: decides when a request is executed
module rqscp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output rqscp_pkg::ctrl_cmd_t cmd
);

    rqscp_pkg::ctrl_state_t state_reg;
    rqscp_pkg::ctrl_state_t state_next;
    logic                   room;

    // Room in the output register when empty or being drained this cycle
    assign room = (state_reg == rqscp_pkg::OUT_EMPTY) || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rqscp_pkg::OUT_EMPTY:
            begin
                if (s_tvalid)
                begin
                    state_next = rqscp_pkg::OUT_FULL;
                end
            end
            rqscp_pkg::OUT_FULL:
            begin
                if (m_tready && !s_tvalid)
                begin
                    state_next = rqscp_pkg::OUT_EMPTY;
                end
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready = room;
        m_tvalid = (state_reg == rqscp_pkg::OUT_FULL);
        cmd.step = s_tvalid && room;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqscp_pkg::OUT_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A stalled result stays presented
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

endmodule

// ===== design/rqscp_dpath.sv =====
// Datapath: descriptor store, pointers, buffer pools, config and result register
module rqscp_dpath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rqscp_pkg::ctrl_cmd_t                 cmd,
    input  rqscp_pkg::request_t                  req,
    input  logic                                 cfg_we,
    input  logic [rqscp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rqscp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rqscp_pkg::result_t                   result
);

    // Block size registers
    logic [rqscp_pkg::LEN_W-1:0] small_bytes_reg;
    logic [rqscp_pkg::LEN_W-1:0] medium_bytes_reg;
    logic [rqscp_pkg::LEN_W-1:0] large_bytes_reg;

    // Queue state
    rqscp_pkg::entry_t                  store_reg [rqscp_pkg::QUEUE_DEPTH];
    rqscp_pkg::entry_t                  head_reg;
    rqscp_pkg::entry_t                  head_next;
    logic [rqscp_pkg::PTR_W-1:0]        wr_reg;
    logic [rqscp_pkg::PTR_W-1:0]        wr_next;
    logic [rqscp_pkg::PTR_W-1:0]        rd_reg;
    logic [rqscp_pkg::PTR_W-1:0]        rd_next;
    logic [rqscp_pkg::CNT_W-1:0]        occ_reg;
    logic [rqscp_pkg::CNT_W-1:0]        occ_next;
    logic [rqscp_pkg::SMALL_BUFFERS-1:0]  small_used_reg;
    logic [rqscp_pkg::SMALL_BUFFERS-1:0]  small_used_next;
    logic [rqscp_pkg::MEDIUM_BUFFERS-1:0] medium_used_reg;
    logic [rqscp_pkg::MEDIUM_BUFFERS-1:0] medium_used_next;
    logic [rqscp_pkg::LARGE_BUFFERS-1:0]  large_used_reg;
    logic [rqscp_pkg::LARGE_BUFFERS-1:0]  large_used_next;

    rqscp_pkg::result_t                 result_reg;
    rqscp_pkg::result_t                 result_next;

    // Allocation helpers
    rqscp_pkg::pick_t                   small_pick;
    rqscp_pkg::pick_t                   medium_pick;
    rqscp_pkg::pick_t                   large_pick;
    rqscp_pkg::entry_t                  new_entry;
    logic                               store_we;
    logic                               is_full;
    logic                               is_empty;

    assign is_full  = (occ_reg == rqscp_pkg::CNT_W'(rqscp_pkg::QUEUE_DEPTH));
    assign is_empty = (occ_reg == '0);

    // Find the lowest free buffer in each class
    always_comb
    begin
        small_pick  = rqscp_pkg::lowest_free(rqscp_pkg::POOL_MAX'(small_used_reg));
        medium_pick = rqscp_pkg::lowest_free(
            {{(rqscp_pkg::POOL_MAX - rqscp_pkg::MEDIUM_BUFFERS){1'b1}}, medium_used_reg});
        large_pick  = rqscp_pkg::lowest_free(
            {{(rqscp_pkg::POOL_MAX - rqscp_pkg::LARGE_BUFFERS){1'b1}}, large_used_reg});
    end

    // Execute one request
    always_comb
    begin
        small_used_next  = small_used_reg;
        medium_used_next = medium_used_reg;
        large_used_next  = large_used_reg;
        wr_next          = wr_reg;
        rd_next          = rd_reg;
        occ_next         = occ_reg;
        head_next        = head_reg;
        store_we         = 1'b0;
        result_next.status = rqscp_pkg::ST_DONE;

        new_entry.msg_kind             = req.msg_kind;
        new_entry.remote_addr          = req.remote_addr;
        new_entry.source_addr          = req.source_addr;
        new_entry.target_addr          = req.target_addr;
        new_entry.target_is_functional = req.target_is_functional;
        new_entry.payload_len          = req.payload_len;
        new_entry.buf_class            = rqscp_pkg::CLS_NONE;
        new_entry.buf_index            = '0;

        // Try classes smallest first, each against its own block size
        if (req.payload_len <= small_bytes_reg && small_pick.found)
        begin
            new_entry.buf_class = rqscp_pkg::CLS_SMALL;
            new_entry.buf_index = small_pick.index;
        end
        else if (req.payload_len <= medium_bytes_reg && medium_pick.found)
        begin
            new_entry.buf_class = rqscp_pkg::CLS_MEDIUM;
            new_entry.buf_index = medium_pick.index;
        end
        else if (req.payload_len <= large_bytes_reg && large_pick.found)
        begin
            new_entry.buf_class = rqscp_pkg::CLS_LARGE;
            new_entry.buf_index = large_pick.index;
        end

        unique case (req.action)
            rqscp_pkg::ACT_ENQUEUE:
            begin
                if (is_full)
                begin
                    result_next.status = rqscp_pkg::ST_FULL;
                end
                else if (new_entry.buf_class == rqscp_pkg::CLS_NONE)
                begin
                    result_next.status = rqscp_pkg::ST_NOFIT;
                end
                else
                begin
                    store_we = 1'b1;
                    wr_next  = rqscp_pkg::ptr_inc(wr_reg);
                    occ_next = occ_reg + 1'b1;
                    if (is_empty)
                    begin
                        head_next = new_entry;
                    end
                    unique case (new_entry.buf_class)
                        rqscp_pkg::CLS_SMALL:
                            small_used_next = small_used_reg
                                | (rqscp_pkg::SMALL_BUFFERS'(1) << new_entry.buf_index);
                        rqscp_pkg::CLS_MEDIUM:
                            medium_used_next = medium_used_reg
                                | (rqscp_pkg::MEDIUM_BUFFERS'(1) << new_entry.buf_index);
                        default:
                            large_used_next = large_used_reg
                                | (rqscp_pkg::LARGE_BUFFERS'(1) << new_entry.buf_index);
                    endcase
                end
            end
            rqscp_pkg::ACT_DEQUEUE:
            begin
                if (is_empty)
                begin
                    result_next.status = rqscp_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_next   = rqscp_pkg::ptr_inc(rd_reg);
                    occ_next  = occ_reg - 1'b1;
                    head_next = store_reg[rd_next];
                    // Release the head's buffer
                    unique case (head_reg.buf_class)
                        rqscp_pkg::CLS_SMALL:
                            small_used_next = small_used_reg
                                & ~(rqscp_pkg::SMALL_BUFFERS'(1) << head_reg.buf_index);
                        rqscp_pkg::CLS_MEDIUM:
                            medium_used_next = medium_used_reg
                                & ~(rqscp_pkg::MEDIUM_BUFFERS'(1) << head_reg.buf_index);
                        default:
                            large_used_next = large_used_reg
                                & ~(rqscp_pkg::LARGE_BUFFERS'(1) << head_reg.buf_index);
                    endcase
                end
            end
            default:
            begin
                // Peek and the unused action: report only
            end
        endcase

        result_next.entry_count = occ_next;
        result_next.head_valid  = (occ_next != '0);
        result_next.head        = (occ_next != '0) ? head_next : '0;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_bytes_reg  <= rqscp_pkg::SMALL_BYTES_RST;
            medium_bytes_reg <= rqscp_pkg::MEDIUM_BYTES_RST;
            large_bytes_reg  <= rqscp_pkg::LARGE_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rqscp_pkg::CFG_SMALL_BYTES:  small_bytes_reg  <= cfg_wdata;
                rqscp_pkg::CFG_MEDIUM_BYTES: medium_bytes_reg <= cfg_wdata;
                rqscp_pkg::CFG_LARGE_BYTES:  large_bytes_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg          <= '0;
            rd_reg          <= '0;
            occ_reg         <= '0;
            small_used_reg  <= '0;
            medium_used_reg <= '0;
            large_used_reg  <= '0;
        end
        else if (cmd.step)
        begin
            wr_reg          <= wr_next;
            rd_reg          <= rd_next;
            occ_reg         <= occ_next;
            small_used_reg  <= small_used_next;
            medium_used_reg <= medium_used_next;
            large_used_reg  <= large_used_next;
        end
    end

    // Descriptor store, head copy and result register
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            head_reg   <= head_next;
            result_reg <= result_next;
            if (store_we)
            begin
                store_reg[wr_reg] <= new_entry;
            end
        end
    end

    assign result = result_reg;

    // Occupancy stays within the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= rqscp_pkg::CNT_W'(rqscp_pkg::QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // Read pointer plus occupancy lands on the write pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        rqscp_pkg::PTR_W'((32'(rd_reg) + 32'(occ_reg)) % rqscp_pkg::QUEUE_DEPTH) == wr_reg)
        else $error("queue pointers out of step with occupancy");

    // Every queued entry holds exactly one buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(small_used_reg) + $countones(medium_used_reg)
            + $countones(large_used_reg)) == 32'(occ_reg))
        else $error("buffers in use differ from occupancy");

    // A result reports the occupancy the step left behind
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> result_reg.entry_count == occ_reg)
        else $error("reported count differs from occupancy");

endmodule

// ===== design/request_queue_with_size_class_pool.sv =====
// Request queue with a size-class buffer pool.
//
// Input stream (s_*): one transaction per request. s_tuser carries the action
// (enqueue, dequeue, peek); s_tdata carries the descriptor and payload length.
// Output stream (m_*): exactly one result transaction per request, with the
// status in m_tuser and the queue count and head descriptor in m_tdata.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the small, medium and large
// block sizes; write only while no result is outstanding.
//
// A request accepted at one edge is executed in that cycle and its result is
// registered and presented on m_* from the next cycle. Throughput is one
// request per cycle while the receiver takes each result: the whole step
// (length compares, lowest-free search over each pool, pointer and flag
// update) is combinational into the result register.
// When the receiver stalls, the result register holds and s_tready drops
// until it is taken; a request is accepted in the same cycle the held result
// leaves. Reset empties the queue, frees all buffers, restores the default
// block sizes (64, 256, 4096) and clears the output valid.
module request_queue_with_size_class_pool
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // msg_kind[7:0], remote_addr[23:8], source_addr[39:24], target_addr[55:40],
    // target_is_functional[56], payload_len[72:57], zero fill
    input  logic [rqscp_pkg::S_TDATA_W-1:0]      s_tdata,
    // action[1:0]
    input  logic [rqscp_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // entry_count[3:0], head_valid[4], head_msg_kind[12:5],
    // head_remote_addr[28:13], head_source_addr[44:29], head_target_addr[60:45],
    // head_target_is_functional[61], head_payload_len[77:62],
    // head_buffer_class[79:78], head_buffer_index[82:80], zero fill
    output logic [rqscp_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [rqscp_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                 cfg_we,
    input  logic [rqscp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rqscp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    rqscp_pkg::ctrl_cmd_t cmd;
    rqscp_pkg::request_t  req;
    rqscp_pkg::result_t   result;

    // Unpack the request
    always_comb
    begin
        req.action               = rqscp_pkg::action_t'(s_tuser);
        req.msg_kind             = s_tdata[7:0];
        req.remote_addr          = s_tdata[23:8];
        req.source_addr          = s_tdata[39:24];
        req.target_addr          = s_tdata[55:40];
        req.target_is_functional = s_tdata[56];
        req.payload_len          = s_tdata[72:57];
    end

    rqscp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rqscp_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    // Pack the result
    assign m_tuser = result.status;
    assign m_tdata = {
        5'd0,
        result.head.buf_index,
        result.head.buf_class,
        result.head.payload_len,
        result.head.target_is_functional,
        result.head.target_addr,
        result.head.source_addr,
        result.head.remote_addr,
        result.head.msg_kind,
        result.head_valid,
        result.entry_count
    };

endmodule

// ===== sim/tb_request_queue_with_size_class_pool.sv =====
`timescale 1ns / 1ps

module tb_request_queue_with_size_class_pool;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    // msg_kind, remote_addr, source_addr, target_addr, target_is_functional,
    // payload_len, zero fill
    logic [rqscp_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    // action
    logic [rqscp_pkg::S_TUSER_W-1:0]   s_tuser   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    // entry_count, head_valid, head_msg_kind, head_remote_addr, head_source_addr,
    // head_target_addr, head_target_is_functional, head_payload_len,
    // head_buffer_class, head_buffer_index, zero fill
    logic [rqscp_pkg::M_TDATA_W-1:0]   m_tdata;
    // status
    logic [rqscp_pkg::M_TUSER_W-1:0]   m_tuser;
    logic                              cfg_we    = 1'b0;
    logic [rqscp_pkg::CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [rqscp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Requests waiting for the bus, the one on the bus, and predicted results
    rqscp_pkg::request_t request_backlog[$];
    rqscp_pkg::request_t on_bus;
    rqscp_pkg::result_t  expected_results[$];

    // Shadow of the queue, the buffer pools and the block sizes
    rqscp_pkg::entry_t slot_entry [rqscp_pkg::QUEUE_DEPTH];
    int           wr_slot    = 0;
    int           rd_slot    = 0;
    int           held_count = 0;
    logic [7:0]   pool_used  [3] = '{8'h00, 8'h00, 8'h00};
    int           pool_size  [3] = '{rqscp_pkg::SMALL_BUFFERS, rqscp_pkg::MEDIUM_BUFFERS,
                                     rqscp_pkg::LARGE_BUFFERS};
    logic [15:0]  block_bytes [3] = '{rqscp_pkg::SMALL_BYTES_RST,
                                      rqscp_pkg::MEDIUM_BYTES_RST,
                                      rqscp_pkg::LARGE_BYTES_RST};

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int full_seen      = 0;
    int nofit_seen     = 0;
    int empty_seen     = 0;

    request_queue_with_size_class_pool i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Take the lowest free buffer of a class, -1 when the class is exhausted
    function automatic int claim_buffer(int cls);
        int got = -1;
        for (int i = 0; i < pool_size[cls]; i++)
        begin
            if (got < 0 && !pool_used[cls][i])
            begin
                pool_used[cls][i] = 1'b1;
                got = i;
            end
        end
        return got;
    endfunction

    // Apply one request to the shadow queue and return the result it causes
    function automatic rqscp_pkg::result_t advance_queue_model(rqscp_pkg::request_t req);
        rqscp_pkg::result_t res;
        int      got;
        int      cls;
        res = '0;
        res.status = rqscp_pkg::ST_DONE;
        case (req.action)
            rqscp_pkg::ACT_ENQUEUE:
            begin
                if (held_count >= rqscp_pkg::QUEUE_DEPTH)
                begin
                    res.status = rqscp_pkg::ST_FULL;
                end
                else
                begin
                    got = -1;
                    cls = 0;
                    // smallest fitting class first, fall back to larger ones
                    for (int c = 0; c < 3; c++)
                    begin
                        if (got < 0 && req.payload_len <= block_bytes[c])
                        begin
                            got = claim_buffer(c);
                            if (got >= 0)
                                cls = c;
                        end
                    end
                    if (got < 0)
                    begin
                        res.status = rqscp_pkg::ST_NOFIT;
                    end
                    else
                    begin
                        slot_entry[wr_slot].msg_kind             = req.msg_kind;
                        slot_entry[wr_slot].remote_addr          = req.remote_addr;
                        slot_entry[wr_slot].source_addr          = req.source_addr;
                        slot_entry[wr_slot].target_addr          = req.target_addr;
                        slot_entry[wr_slot].target_is_functional = req.target_is_functional;
                        slot_entry[wr_slot].payload_len          = req.payload_len;
                        slot_entry[wr_slot].buf_class = rqscp_pkg::buf_class_t'(cls);
                        slot_entry[wr_slot].buf_index = rqscp_pkg::IDX_W'(got);
                        held_count++;
                        wr_slot = (wr_slot + 1) % rqscp_pkg::QUEUE_DEPTH;
                    end
                end
            end
            rqscp_pkg::ACT_DEQUEUE:
            begin
                if (held_count == 0)
                begin
                    res.status = rqscp_pkg::ST_EMPTY;
                end
                else
                begin
                    // release the head buffer
                    pool_used[int'(slot_entry[rd_slot].buf_class)]
                             [slot_entry[rd_slot].buf_index] = 1'b0;
                    held_count--;
                    rd_slot = (rd_slot + 1) % rqscp_pkg::QUEUE_DEPTH;
                end
            end
            default:
            begin
                // peek and the unused code change nothing
            end
        endcase
        res.entry_count = rqscp_pkg::CNT_W'(held_count);
        if (held_count != 0)
        begin
            res.head_valid = 1'b1;
            res.head       = slot_entry[rd_slot];
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] result %0d: %s is %0h, expected %0h",
                 $time, results_seen, field, got, want);
        mismatch_count++;
    endtask

    // Compare one output transaction with the oldest prediction
    task automatic check_result(logic [rqscp_pkg::M_TDATA_W-1:0] data,
                                logic [rqscp_pkg::M_TUSER_W-1:0] user);
        rqscp_pkg::result_t got;
        rqscp_pkg::result_t want;
        got.status                    = rqscp_pkg::status_t'(user);
        got.entry_count               = data[3:0];
        got.head_valid                = data[4];
        got.head.msg_kind             = data[12:5];
        got.head.remote_addr          = data[28:13];
        got.head.source_addr          = data[44:29];
        got.head.target_addr          = data[60:45];
        got.head.target_is_functional = data[61];
        got.head.payload_len          = data[77:62];
        got.head.buf_class            = rqscp_pkg::buf_class_t'(data[79:78]);
        got.head.buf_index            = data[82:80];
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with nothing pending, status", got.status, 0);
        end
        else
        begin
            want = expected_results.pop_front();
            case (want.status)
                rqscp_pkg::ST_FULL:  full_seen++;
                rqscp_pkg::ST_NOFIT: nofit_seen++;
                rqscp_pkg::ST_EMPTY: empty_seen++;
                default:  ;
            endcase
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", got.entry_count, want.entry_count);
            if (got.head_valid !== want.head_valid)
                report_mismatch("head_valid", got.head_valid, want.head_valid);
            if (got.head.msg_kind !== want.head.msg_kind)
                report_mismatch("head_msg_kind", got.head.msg_kind, want.head.msg_kind);
            if (got.head.remote_addr !== want.head.remote_addr)
                report_mismatch("head_remote_addr", got.head.remote_addr,
                                want.head.remote_addr);
            if (got.head.source_addr !== want.head.source_addr)
                report_mismatch("head_source_addr", got.head.source_addr,
                                want.head.source_addr);
            if (got.head.target_addr !== want.head.target_addr)
                report_mismatch("head_target_addr", got.head.target_addr,
                                want.head.target_addr);
            if (got.head.target_is_functional !== want.head.target_is_functional)
                report_mismatch("head_target_is_functional",
                                got.head.target_is_functional,
                                want.head.target_is_functional);
            if (got.head.payload_len !== want.head.payload_len)
                report_mismatch("head_payload_len", got.head.payload_len,
                                want.head.payload_len);
            if (got.head.buf_class !== want.head.buf_class)
                report_mismatch("head_buffer_class", got.head.buf_class,
                                want.head.buf_class);
            if (got.head.buf_index !== want.head.buf_index)
                report_mismatch("head_buffer_index", got.head.buf_index,
                                want.head.buf_index);
        end
        results_seen++;
    endtask

    // Driver: predict on each accepted transaction, then present the next request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(advance_queue_model(on_bus));
                requests_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = request_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.action;
                    s_tdata  <= {7'b0, on_bus.payload_len, on_bus.target_is_functional,
                                 on_bus.target_addr, on_bus.source_addr,
                                 on_bus.remote_addr, on_bus.msg_kind};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic rqscp_pkg::request_t make_request(rqscp_pkg::action_t act,
                                                         logic [15:0] len);
        rqscp_pkg::request_t req;
        req.action               = act;
        req.msg_kind             = 8'($urandom);
        req.remote_addr          = 16'($urandom);
        req.source_addr          = 16'($urandom);
        req.target_addr          = 16'($urandom);
        req.target_is_functional = 1'($urandom);
        req.payload_len          = len;
        return req;
    endfunction

    function automatic void push_request(rqscp_pkg::action_t act, logic [15:0] len);
        request_backlog.push_back(make_request(act, len));
    endfunction

    // Lengths cluster around the current block sizes, with some extremes
    function automatic logic [15:0] pick_length();
        int pick;
        int len;
        pick = $urandom_range(9);
        if (pick == 0)
            len = 0;
        else if (pick == 1)
            len = 65535;
        else if (pick <= 3)
            len = $urandom_range(65535);
        else
        begin
            len = int'(block_bytes[$urandom_range(2)]) + $urandom_range(2) - 1;
            if (len < 0)
                len = 0;
            if (len > 65535)
                len = 65535;
        end
        return 16'(len);
    endfunction

    // Alternate fill and drain tides so the queue and pools swing full and empty
    task automatic queue_random_traffic(int count);
        bit                 filling;
        int                 pick;
        rqscp_pkg::action_t act;
        filling = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(7) == 0)
                filling = !filling;
            pick = $urandom_range(99);
            if (pick < (filling ? 65 : 20))
                act = rqscp_pkg::ACT_ENQUEUE;
            else if (pick < 85)
                act = rqscp_pkg::ACT_DEQUEUE;
            else if (pick < 95)
                act = rqscp_pkg::ACT_PEEK;
            else
                act = rqscp_pkg::ACT_UNUSED;
            push_request(act, pick_length());
        end
    endtask

    // Hold the sender until every predicted result has come back
    task automatic wait_until_drained();
        while (request_backlog.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_block_size(logic [rqscp_pkg::CFG_ADDR_W-1:0] idx,
                                    logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        block_bytes[int'(idx)] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_block_sizes(logic [15:0] small_b, logic [15:0] medium_b,
                                   logic [15:0] large_b);
        write_block_size(rqscp_pkg::CFG_SMALL_BYTES, small_b);
        write_block_size(rqscp_pkg::CFG_MEDIUM_BYTES, medium_b);
        write_block_size(rqscp_pkg::CFG_LARGE_BYTES, large_b);
    endtask

    // Stimulus sequence
    initial
    begin
        rqscp_pkg::request_t req;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, class boundaries, fallback, full, exhaustion
        push_request(rqscp_pkg::ACT_DEQUEUE, 16'd0);
        push_request(rqscp_pkg::ACT_PEEK, 16'd0);
        req = make_request(rqscp_pkg::ACT_ENQUEUE, 16'd0);
        req.msg_kind = '0;
        req.remote_addr = '0;
        req.source_addr = '0;
        req.target_addr = '0;
        req.target_is_functional = 1'b0;
        request_backlog.push_back(req);
        req = make_request(rqscp_pkg::ACT_ENQUEUE, 16'd64);
        req.msg_kind = '1;
        req.remote_addr = '1;
        req.source_addr = '1;
        req.target_addr = '1;
        req.target_is_functional = 1'b1;
        request_backlog.push_back(req);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd65);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd256);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd200);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd100);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd150);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd4096);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd4097);
        push_request(rqscp_pkg::ACT_DEQUEUE, 16'd0);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd4097);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd300);
        push_request(rqscp_pkg::ACT_ENQUEUE, 16'd5);
        push_request(rqscp_pkg::ACT_UNUSED, 16'hFFFF);
        repeat (8) push_request(rqscp_pkg::ACT_DEQUEUE, 16'd0);
        push_request(rqscp_pkg::ACT_DEQUEUE, 16'd0);
        wait_until_drained();

        // No idling; small class only serves zero length
        set_block_sizes(16'd0, 16'd65535, 16'd65535);
        queue_random_traffic(110);
        wait_until_drained();

        // Sender idles; block sizes out of order
        send_idle_pct = 63;
        set_block_sizes(16'd1000, 16'd10, 16'd0);
        queue_random_traffic(110);
        wait_until_drained();

        // Receiver stalls; medium class unreachable
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        set_block_sizes(16'd65535, 16'd0, 16'd300);
        queue_random_traffic(110);
        wait_until_drained();

        // Both sides idle; random block sizes
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        set_block_sizes(16'($urandom_range(400)), 16'($urandom_range(3000)),
                        16'($urandom_range(65535)));
        queue_random_traffic(110);
        wait_until_drained();
        repeat (4) @(posedge clk);

        $display("requests sent %0d, results checked %0d over five block-size settings",
                 requests_sent, results_seen);
        $display("refused: %0d queue full, %0d no buffer fits, %0d dequeue on empty",
                 full_seen, nofit_seen, empty_seen);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
